// File: src/euler_angles_to_basis_vectors_macros.svh
// assertion macros, empty when synthesized
`ifndef EULER_ANGLES_TO_BASIS_VECTORS_MACROS_SVH
`define EULER_ANGLES_TO_BASIS_VECTORS_MACROS_SVH
`ifndef SYNTHESIS
`define EABV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define EABV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EABV_ASSERT_NOW(label, ante, cons, msg)
`define EABV_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: src/eabv_pkg.sv
package eabv_pkg;

    localparam int ANGLE_WIDTH   = 16;
    localparam int FRACTION_BITS = 14;
    localparam int FIELD_W       = 16;
    localparam int IN_W          = 3 * FIELD_W;
    localparam int OUT_W         = 9 * FIELD_W;

    localparam int TURN_W  = 32;
    localparam int RESID_W = TURN_W - 2;
    localparam int TRIG_W  = 32;
    localparam int PROD_W  = 2 * TRIG_W;
    localparam int RND_SH  = 2 * RESID_W - FRACTION_BITS;
    localparam int RND_W   = PROD_W - RND_SH;

    localparam int SAT_HI = (FRACTION_BITS >= 15) ? 32767 : (1 << FRACTION_BITS);
    localparam int SAT_LO = (FRACTION_BITS >= 15) ? -32768 : -(1 << FRACTION_BITS);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int ATAN_N = 24;
    localparam logic signed [TRIG_W-1:0] CORDIC_K = 32'sd652032874;
    localparam logic signed [TRIG_W-1:0] ATAN_TAB [ATAN_N] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    typedef enum logic [1:0] {
        QUAD_I,
        QUAD_II,
        QUAD_III,
        QUAD_IV
    } t_quad;

    typedef struct packed {
        t_quad              quad;
        logic [RESID_W-1:0] resid;
    } t_angle;

    typedef struct packed {
        t_angle roll;
        t_angle yaw;
        t_angle pitch;
    } t_item;

    typedef struct packed {
        logic signed [TRIG_W-1:0] co;
        logic signed [TRIG_W-1:0] si;
    } t_trig;

endpackage

// File: src/eabv_front.sv
`include "euler_angles_to_basis_vectors_macros.svh"

module eabv_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [eabv_pkg::IN_W-1:0] i_data,
    output logic                      o_push,
    output eabv_pkg::t_item           o_item,
    input  logic                      i_full
);
    import eabv_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    t_item n_item;
    logic  w_take;

    function automatic t_angle classify(input logic [FIELD_W-1:0] a);
        logic [ANGLE_WIDTH-1:0] w;
        logic [TURN_W-1:0]      t;
        t_angle                 c;
        w       = ANGLE_WIDTH'(a);
        t       = {w, (TURN_W - ANGLE_WIDTH)'(0)};
        c.quad  = t_quad'(t[TURN_W-1 -: 2]);
        c.resid = t[RESID_W-1:0];
        return c;
    endfunction

    assign o_ready = !r_valid || !i_full;
    assign o_push  = r_valid && !i_full;
    assign o_item  = r_item;
    assign w_take  = i_valid && o_ready;

    always_comb begin
        n_valid = w_take || (r_valid && i_full);
        n_item  = r_item;
        if (w_take) begin
            n_item.pitch = classify(i_data[FIELD_W-1:0]);
            n_item.yaw   = classify(i_data[2*FIELD_W-1:FIELD_W]);
            n_item.roll  = classify(i_data[3*FIELD_W-1:2*FIELD_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    `EABV_ASSERT_NEXT(a_held_item_kept, r_valid && i_full, r_valid && $stable(r_item), "front item lost while queue full")

endmodule

// File: src/eabv_fifo.sv
`include "euler_angles_to_basis_vectors_macros.svh"

module eabv_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  eabv_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output eabv_pkg::t_item o_item
);
    import eabv_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;
    logic [QPTR_W-1:0] n_wr;
    logic [QPTR_W-1:0] n_rd;
    logic [QPTR_W:0]   n_count;

    assign o_full  = r_count == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    `EABV_ASSERT_NOW(a_no_push_full, i_push, !o_full, "push into full queue")
    `EABV_ASSERT_NOW(a_no_pop_empty, i_pop, o_valid, "pop from empty queue")

endmodule

// File: src/eabv_cordic.sv
module eabv_cordic #(
    parameter int ITERS = 16
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  eabv_pkg::t_angle i_angle,
    output eabv_pkg::t_trig  o_trig
);
    import eabv_pkg::*;

    logic signed [TRIG_W-1:0] r_x [ITERS+1];
    logic signed [TRIG_W-1:0] r_y [ITERS+1];
    logic signed [TRIG_W-1:0] r_z [ITERS+1];
    t_quad                    r_q [ITERS+1];
    t_trig                    r_trig;
    t_trig                    n_trig;

    assign o_trig = r_trig;

    // quadrant applied by swap and negate
    always_comb begin
        case (r_q[ITERS])
            QUAD_I: begin
                n_trig.co = r_x[ITERS];
                n_trig.si = r_y[ITERS];
            end
            QUAD_II: begin
                n_trig.co = -r_y[ITERS];
                n_trig.si = r_x[ITERS];
            end
            QUAD_III: begin
                n_trig.co = -r_x[ITERS];
                n_trig.si = -r_y[ITERS];
            end
            default: begin
                n_trig.co = r_y[ITERS];
                n_trig.si = -r_x[ITERS];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_K;
            r_y[0] <= '0;
            r_z[0] <= {{(TRIG_W - RESID_W){1'b0}}, i_angle.resid};
            r_q[0] <= i_angle.quad;
            for (int i = 0; i < ITERS; i++) begin
                if (!r_z[i][TRIG_W-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - ATAN_TAB[i];
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + ATAN_TAB[i];
                end
                r_q[i+1] <= r_q[i];
            end
            r_trig <= n_trig;
        end
    end

endmodule

// File: src/eabv_back.sv
`include "euler_angles_to_basis_vectors_macros.svh"

module eabv_back #(
    parameter int ITERS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_pop,
    input  eabv_pkg::t_item            i_item,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [eabv_pkg::OUT_W-1:0] o_data
);
    import eabv_pkg::*;

    localparam int LAT = ITERS + 7;
    localparam logic signed [PROD_W-1:0] HALF_Q   = PROD_W'(1) << (RESID_W - 1);
    localparam logic signed [PROD_W-1:0] HALF_R   = PROD_W'(1) << (RND_SH - 1);
    localparam logic signed [RND_W-1:0]  SAT_HI_R = RND_W'(SAT_HI);
    localparam logic signed [RND_W-1:0]  SAT_LO_R = RND_W'(SAT_LO);

    typedef struct packed {
        logic signed [PROD_W-1:0] cpcy, cpsy, spcy, spsy, srcp, crcp, crsy, crcy, srsy, srcy;
        logic signed [TRIG_W-1:0] sp, sr, cr;
    } t_prod;

    typedef struct packed {
        logic signed [PROD_W-1:0] srspcy, crspcy, srspsy, crspsy;
        logic signed [PROD_W-1:0] cpcy, cpsy, srcp, crcp, crsy, crcy, srsy, srcy;
        logic signed [TRIG_W-1:0] sp;
    } t_mix;

    logic                     w_en;
    logic [LAT-1:0]           r_vld;
    logic                     r_out_valid;
    t_trig                    w_pt;
    t_trig                    w_yt;
    t_trig                    w_rt;
    logic signed [TRIG_W-1:0] w_cp, w_sp, w_cy, w_sy, w_cr, w_sr;
    t_prod                    r_p1;
    t_prod                    r_r1;
    t_mix                     r_p2;
    logic signed [PROD_W-1:0] r_sum [9];
    logic signed [RND_W-1:0]  r_rnd [9];
    logic [OUT_W-1:0]         r_data;
    logic [OUT_W-1:0]         n_data;

    assign w_en    = !r_out_valid || i_ready;
    assign o_pop   = i_valid && w_en;
    assign o_valid = r_out_valid;
    assign o_data  = r_data;

    eabv_cordic #(.ITERS(ITERS)) u_pitch (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_angle(i_item.pitch),
        .o_trig (w_pt)
    );

    eabv_cordic #(.ITERS(ITERS)) u_yaw (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_angle(i_item.yaw),
        .o_trig (w_yt)
    );

    eabv_cordic #(.ITERS(ITERS)) u_roll (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_angle(i_item.roll),
        .o_trig (w_rt)
    );

    assign w_cp = w_pt.co;
    assign w_sp = w_pt.si;
    assign w_cy = w_yt.co;
    assign w_sy = w_yt.si;
    assign w_cr = w_rt.co;
    assign w_sr = w_rt.si;

    always_comb begin
        n_data = '0;
        for (int k = 0; k < 9; k++) begin
            if (r_rnd[k] > SAT_HI_R) begin
                n_data[k*FIELD_W +: FIELD_W] = FIELD_W'(SAT_HI);
            end else if (r_rnd[k] < SAT_LO_R) begin
                n_data[k*FIELD_W +: FIELD_W] = FIELD_W'(SAT_LO);
            end else begin
                n_data[k*FIELD_W +: FIELD_W] = FIELD_W'(r_rnd[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld       <= {r_vld[LAT-2:0], o_pop};
            r_out_valid <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // first products, all q60
            r_p1.cpcy <= w_cp * w_cy;
            r_p1.cpsy <= w_cp * w_sy;
            r_p1.spcy <= w_sp * w_cy;
            r_p1.spsy <= w_sp * w_sy;
            r_p1.srcp <= w_sr * w_cp;
            r_p1.crcp <= w_cr * w_cp;
            r_p1.crsy <= w_cr * w_sy;
            r_p1.crcy <= w_cr * w_cy;
            r_p1.srsy <= w_sr * w_sy;
            r_p1.srcy <= w_sr * w_cy;
            r_p1.sp   <= w_sp;
            r_p1.sr   <= w_sr;
            r_p1.cr   <= w_cr;

            // sp*cy and sp*sy back to q30
            r_r1.cpcy <= r_p1.cpcy;
            r_r1.cpsy <= r_p1.cpsy;
            r_r1.spcy <= (r_p1.spcy + HALF_Q) >>> RESID_W;
            r_r1.spsy <= (r_p1.spsy + HALF_Q) >>> RESID_W;
            r_r1.srcp <= r_p1.srcp;
            r_r1.crcp <= r_p1.crcp;
            r_r1.crsy <= r_p1.crsy;
            r_r1.crcy <= r_p1.crcy;
            r_r1.srsy <= r_p1.srsy;
            r_r1.srcy <= r_p1.srcy;
            r_r1.sp   <= r_p1.sp;
            r_r1.sr   <= r_p1.sr;
            r_r1.cr   <= r_p1.cr;

            r_p2.srspcy <= r_r1.sr * TRIG_W'(r_r1.spcy);
            r_p2.crspcy <= r_r1.cr * TRIG_W'(r_r1.spcy);
            r_p2.srspsy <= r_r1.sr * TRIG_W'(r_r1.spsy);
            r_p2.crspsy <= r_r1.cr * TRIG_W'(r_r1.spsy);
            r_p2.cpcy   <= r_r1.cpcy;
            r_p2.cpsy   <= r_r1.cpsy;
            r_p2.srcp   <= r_r1.srcp;
            r_p2.crcp   <= r_r1.crcp;
            r_p2.crsy   <= r_r1.crsy;
            r_p2.crcy   <= r_r1.crcy;
            r_p2.srsy   <= r_r1.srsy;
            r_p2.srcy   <= r_r1.srcy;
            r_p2.sp     <= r_r1.sp;

            r_sum[0] <= r_p2.cpcy;
            r_sum[1] <= r_p2.cpsy;
            r_sum[2] <= -(PROD_W'(r_p2.sp) <<< RESID_W);
            r_sum[3] <= r_p2.crsy - r_p2.srspcy;
            r_sum[4] <= -r_p2.srspsy - r_p2.crcy;
            r_sum[5] <= -r_p2.srcp;
            r_sum[6] <= r_p2.crspcy + r_p2.srsy;
            r_sum[7] <= r_p2.crspsy - r_p2.srcy;
            r_sum[8] <= r_p2.crcp;

            for (int k = 0; k < 9; k++) begin
                r_rnd[k] <= RND_W'((r_sum[k] + HALF_R) >>> RND_SH);
            end

            r_data <= n_data;
        end
    end

    `EABV_ASSERT_NEXT(a_stall_freezes_pipe, !w_en, $stable(r_vld), "back pipeline moved while stalled")

endmodule

// File: src/euler_angles_to_basis_vectors.sv
// channel   dir  payload                                         handshake
// s_axis    in   pitch_angle, yaw_angle, roll_angle (16 b each)  tvalid/tready
// m_axis    out  fwd, rgt, upv x/y/z (signed q2.14, 16 b each)   tvalid/tready
//
// one item per cycle sustained while m_axis tready stays high
// the cordic is pipelined, one stage per iteration, three lanes in parallel
// reset is synchronous, active low, clears only control state; no clearing pass
// m_axis tready low freezes the back pipeline; s_axis fills a four-entry queue
module euler_angles_to_basis_vectors #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // pitch_angle, yaw_angle, roll_angle
    input  logic [eabv_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // fwd_x, fwd_y, fwd_z, rgt_x, rgt_y, rgt_z, upv_x, upv_y, upv_z
    output logic [eabv_pkg::OUT_W-1:0] o_m_axis_tdata
);
    import eabv_pkg::*;

    logic  w_push;
    logic  w_full;
    logic  w_q_valid;
    logic  w_pop;
    t_item w_front_item;
    t_item w_q_item;

    eabv_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_s_axis_tvalid),
        .o_ready(o_s_axis_tready),
        .i_data (i_s_axis_tdata),
        .o_push (w_push),
        .o_item (w_front_item),
        .i_full (w_full)
    );

    eabv_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_item (w_front_item),
        .o_full (w_full),
        .o_valid(w_q_valid),
        .i_pop  (w_pop),
        .o_item (w_q_item)
    );

    eabv_back #(.ITERS(TRIG_ITERATIONS)) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_q_valid),
        .o_pop  (w_pop),
        .i_item (w_q_item),
        .o_valid(o_m_axis_tvalid),
        .i_ready(i_m_axis_tready),
        .o_data (o_m_axis_tdata)
    );

endmodule
